// ----- rtl/fds_pkg.sv -----
`timescale 1ns / 1ps
// Package for the float to decimal split block.
// Holds the sequencer state type, field widths and the power-of-ten table.
package fds_pkg;

  localparam int unsigned FLOAT_W  = 32;
  localparam int unsigned PLACES_W = 4;
  localparam int unsigned SIG_W    = 24;
  localparam int unsigned SCALE_W  = 30;
  localparam int unsigned PROD_W   = SIG_W + SCALE_W;
  localparam int unsigned Q_W      = 61;
  localparam int unsigned WHOLE_W  = 31;
  localparam int unsigned FRAC_W   = 30;
  localparam int unsigned DIV_STEPS = WHOLE_W;
  localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

  localparam logic [7:0] EXP_BIAS_SHIFT = 8'd150;
  localparam logic [7:0] EXP_BIG       = 8'd158;
  localparam logic [7:0] EXP_SUBNORMAL = 8'd0;
  localparam logic [7:0] SUBNORMAL_T   = 8'd149;
  localparam logic [7:0] MAX_RSHIFT    = 8'd60;
  localparam logic [WHOLE_W-1:0] WHOLE_SAT = {WHOLE_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_DIV,
    ST_FIN
  } fds_state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  function automatic logic [SCALE_W-1:0] pow10(input logic [PLACES_W-1:0] p);
    logic [SCALE_W-1:0] v;
    case (p)
      4'd0: v = 30'd1;
      4'd1: v = 30'd10;
      4'd2: v = 30'd100;
      4'd3: v = 30'd1000;
      4'd4: v = 30'd10000;
      4'd5: v = 30'd100000;
      4'd6: v = 30'd1000000;
      4'd7: v = 30'd10000000;
      4'd8: v = 30'd100000000;
      default: v = 30'd1000000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/fds_divider.sv -----
`timescale 1ns / 1ps
// Restoring divider that splits the rounded scaled value by the power of ten.
// Uses one shared subtractor for the range check and every quotient step.
// Depends on fds_pkg.
module fds_divider
  import fds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  div_ctrl_t          ctrl,
  input  logic [Q_W-1:0]     dividend,
  input  logic [SCALE_W-1:0] divisor,
  output div_stat_t          stat,
  output logic [WHOLE_W-1:0] quot,
  output logic [FRAC_W-1:0]  rem
);

  logic               run_r, run_nxt;
  logic               chk_r, chk_nxt;
  logic               done_r, done_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FRAC_W-1:0]  rem_r, rem_nxt;
  logic [WHOLE_W-1:0] work_r, work_nxt;

  logic [WHOLE_W-1:0] opa;
  logic [WHOLE_W:0]   diff;
  logic               ge;

  assign opa  = chk_r ? {1'b0, rem_r} : {rem_r, work_r[WHOLE_W-1]};
  assign diff = {1'b0, opa} - {2'b00, divisor};
  assign ge   = ~diff[WHOLE_W];

  always_comb begin
    run_nxt  = run_r;
    chk_nxt  = chk_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    if (ctrl.start) begin
      run_nxt  = 1'b1;
      chk_nxt  = 1'b1;
      ovf_nxt  = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = dividend[Q_W-1:WHOLE_W];
      work_nxt = dividend[WHOLE_W-1:0];
    end else if (run_r && chk_r) begin
      if (ge) begin
        ovf_nxt  = 1'b1;
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        chk_nxt = 1'b0;
      end
    end else if (run_r) begin
      rem_nxt  = ge ? diff[FRAC_W-1:0] : opa[FRAC_W-1:0];
      work_nxt = {work_r[WHOLE_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      chk_r  <= chk_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quot      = work_r;
  assign rem       = rem_r;

endmodule

// ----- rtl/float_to_decimal_split.sv -----
`timescale 1ns / 1ps
// Top level of the float to decimal split block.
// Depends on fds_pkg and fds_divider.
//
// The input channel carries a single-precision bit pattern and a count of
// decimal places. Each item gives one result: the sign bit, the integer part
// and the fractional digits of the magnitude rounded half up, plus an
// overflow flag for infinity, NaN or an integer part above 2^31-1.
// An item passes from acceptance to out_tvalid through these steps: the
// significand times power-of-ten product, the rounding shift, one range
// check and 31 quotient steps on the shared subtractor of the divider, a
// state to see the divider finish and the load of the output register.
// Exponents too large to fit skip the divider and go from the product to
// the output load; an integer part caught by the range check ends the
// divider early. in_tready is high only while the sequencer is idle, which
// it reaches the cycle after the output register loads, so a new item is
// accepted only after the last result has loaded. If the receiver stalls,
// the result holds in the output register; a finished item then waits in
// the sequencer until that register frees, and no new item is taken. A
// synchronous reset returns the sequencer to idle and clears out_tvalid.
module float_to_decimal_split
  import fds_pkg::*;
#(
  parameter int unsigned MAX_PLACES = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: float_bits[31:0], decimal_places[35:32], zero pad.
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: is_negative[0], whole_part[31:1],
  // fraction_digits[61:32], zero pad.
  output logic [63:0] out_tdata,
  // Fields from bit 0: overflow[0].
  output logic        out_tuser
);

  fds_state_t state_r, state_nxt;

  logic [FLOAT_W-1:0] bits_r;
  logic [SCALE_W-1:0] scale_r;
  logic [PROD_W-1:0]  prod_r;
  logic               big_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_neg_r;
  logic [WHOLE_W-1:0] out_whole_r;
  logic [FRAC_W-1:0]  out_frac_r;
  logic               out_ovf_r;

  logic [PLACES_W-1:0] places, places_sat;
  logic [7:0]          expo;
  logic [SIG_W-1:0]    sig;
  logic [PROD_W-1:0]   prod;
  logic [7:0]          lshift, rshift;
  logic [PROD_W:0]     rsum;
  logic [Q_W-1:0]      q_nxt;

  logic accept, load_out, fin_ovf;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [WHOLE_W-1:0] div_quot;
  logic [FRAC_W-1:0]  div_rem;

  assign places     = in_tdata[35:32];
  assign places_sat = (places > PLACES_W'(MAX_PLACES)) ? PLACES_W'(MAX_PLACES) : places;

  assign expo = bits_r[30:23];
  assign sig  = (expo == EXP_SUBNORMAL) ? {1'b0, bits_r[22:0]} : {1'b1, bits_r[22:0]};
  assign prod = sig * scale_r;

  assign lshift = expo - EXP_BIAS_SHIFT;
  assign rshift = (expo == EXP_SUBNORMAL) ? SUBNORMAL_T : (EXP_BIAS_SHIFT - expo);
  assign rsum   = {1'b0, prod_r} + ((PROD_W+1)'(1) << (rshift[5:0] - 6'd1));

  always_comb begin
    if (expo >= EXP_BIAS_SHIFT) begin
      q_nxt = {{(Q_W-PROD_W){1'b0}}, prod_r} << lshift[2:0];
    end else if (rshift > MAX_RSHIFT) begin
      q_nxt = '0;
    end else begin
      q_nxt = Q_W'(rsum >> rshift[5:0]);
    end
  end

  assign accept   = in_tvalid && in_tready;
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign fin_ovf  = big_r || div_stat.ovf;

  always_comb begin
    state_nxt      = state_r;
    div_ctrl.start = 1'b0;
    in_tready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = (expo >= EXP_BIG) ? ST_FIN : ST_RND;
      end
      ST_RND: begin
        div_ctrl.start = 1'b1;
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bits_r  <= in_tdata[31:0];
      scale_r <= pow10(places_sat);
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod;
      big_r  <= (expo >= EXP_BIG);
    end
    if (load_out) begin
      out_neg_r   <= bits_r[31];
      out_ovf_r   <= fin_ovf;
      out_whole_r <= fin_ovf ? WHOLE_SAT : div_quot;
      out_frac_r  <= fin_ovf ? '0 : div_rem;
    end
  end

  fds_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (q_nxt),
    .divisor  (scale_r),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_frac_r, out_whole_r, out_neg_r};
  assign out_tuser  = out_ovf_r;

endmodule

// ----- rtl/fds_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the float to decimal split block, bound to its top level.
// Depends only on the ports of float_to_decimal_split.
module fds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result item dropped while the receiver stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted again while an item is in progress.");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[31:1] == 31'h7FFFFFFF) && (out_tdata[61:32] == 30'd0))
    else $error("Overflow result is not saturated.");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[61:32] < 30'd1000000000) && (out_tdata[63:62] == 2'b00))
    else $error("Fraction digits out of range.");

endmodule

bind float_to_decimal_split fds_checker u_fds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for float_to_decimal_split.
// Depends on fds_pkg and the block's RTL; drives float items with random gaps
// and receiver stalls, and checks every result against an in-bench predictor.
module tb_top;
  import fds_pkg::*;

  localparam int unsigned PLACES_CAP = 9;
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;
  localparam logic [63:0] WHOLE_LIMIT = 64'h7FFF_FFFF;

  typedef struct packed {
    logic               neg;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic               ovf;
  } split_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;

  split_result_t pending_splits[$];
  int unsigned   mismatch_count;
  int unsigned   values_sent;
  int unsigned   results_seen;
  int unsigned   overflows_seen;
  bit            idle_on;
  int unsigned   ready_hold;

  float_to_decimal_split #(.MAX_PLACES(PLACES_CAP)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  // Exact half-up rounding of |v| * 10^places, split into whole and fraction.
  function automatic split_result_t predict_split(input logic [31:0] bits,
                                                  input logic [3:0] places);
    split_result_t r;
    logic [7:0]    ex;
    logic [63:0]   sig;
    logic [63:0]   scale;
    logic [63:0]   prod;
    logic [63:0]   q;
    logic [63:0]   w;
    int            s;
    int            t;
    int unsigned   p;
    r = '0;
    r.neg = bits[31];
    p = (places > PLACES_CAP) ? PLACES_CAP : places;
    scale = 64'd1;
    for (int i = 0; i < p; i++) scale = scale * 64'd10;
    ex = bits[30:23];
    q = 64'd0;
    if (ex == EXP_SPECIAL) begin
      r.ovf = 1'b1;
    end else begin
      if (ex == 8'd0) begin
        sig = {41'd0, bits[22:0]};
        s = -149;
      end else begin
        sig = {40'd0, 1'b1, bits[22:0]};
        s = int'(ex) - 150;
      end
      if (sig == 64'd0) begin
        q = 64'd0;
      end else if (s >= 8) begin
        r.ovf = 1'b1;
      end else begin
        prod = sig * scale;
        if (s >= 0) begin
          q = prod << s;
        end else begin
          t = -s;
          if (t > 60) q = 64'd0;
          else q = (prod + (64'd1 << (t - 1))) >> t;
        end
      end
      if (!r.ovf) begin
        w = q / scale;
        if (w > WHOLE_LIMIT) begin
          r.ovf = 1'b1;
        end else begin
          r.whole = w[WHOLE_W-1:0];
          r.frac = FRAC_W'(q % scale);
        end
      end
    end
    if (r.ovf) begin
      r.whole = '1;
      r.frac = '0;
    end
    return r;
  endfunction

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_value(input logic [31:0] bits, input logic [3:0] places);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 1)) ? idle_cycles() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, places, bits};
    do @(posedge clk); while (!in_tready);
    pending_splits.push_back(predict_split(bits, places));
    values_sent++;
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input split_result_t want,
                               input split_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected neg=%0d whole=%0d frac=%0d ovf=%0d,",
               $realtime, what, want.neg, want.whole, want.frac, want.ovf);
      $display("    got neg=%0d whole=%0d frac=%0d ovf=%0d",
               got.neg, got.whole, got.frac, got.ovf);
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= idle_cycles() - 1;
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    split_result_t got;
    split_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.neg = out_tdata[0];
      got.whole = out_tdata[31:1];
      got.frac = out_tdata[61:32];
      got.ovf = out_tuser;
      results_seen++;
      if (got.ovf) overflows_seen++;
      if (pending_splits.size() == 0) begin
        note_mismatch("result with nothing expected", '0, got);
      end else begin
        want = pending_splits.pop_front();
        if (got !== want) note_mismatch("result differs", want, got);
      end
    end
  end

  task automatic test_directed_rounding();
    send_value(32'h0000_0000, 4'd3);
    send_value(32'h8000_0000, 4'd3);
    send_value(32'h0000_0001, 4'd9);
    send_value(32'h007F_FFFF, 4'd9);
    send_value(32'h0080_0000, 4'd9);
    send_value(32'h3F80_0000, 4'd0);
    send_value(32'h3F00_0000, 4'd0);
    send_value(32'h4020_0000, 4'd0);
    send_value(32'hC020_0000, 4'd0);
    send_value(32'h3E00_0000, 4'd2);
    send_value(32'h3F7F_FFFF, 4'd0);
    send_value(32'h3F7F_FFFF, 4'd9);
    send_value(32'h4EFF_FFFF, 4'd9);
    send_value(32'h42F6_E979, 4'd4);
  endtask

  task automatic test_special_encodings();
    send_value(32'h4F00_0000, 4'd0);
    send_value(32'h7F7F_FFFF, 4'd5);
    send_value(32'h7F80_0000, 4'd2);
    send_value(32'hFF80_0000, 4'd2);
    send_value(32'h7FC0_0000, 4'd1);
    send_value(32'h7F80_0001, 4'd0);
    send_value(32'hFFFF_FFFF, 4'd9);
  endtask

  task automatic test_place_clamp();
    send_value(32'h3F9E_0419, 4'd8);
    send_value(32'h3F9E_0419, 4'd10);
    send_value(32'hBF9E_0419, 4'd12);
    send_value(32'h3F9E_0419, 4'd15);
  endtask

  task automatic test_random_values(input int unsigned count);
    logic [31:0] bits;
    logic [7:0]  ex;
    logic [22:0] frac;
    logic [3:0]  places;
    int unsigned kind;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 250 == 0) idle_on = (i / 250) % 2 == 0;
      kind = $urandom_range(0, 99);
      frac = 23'($urandom());
      if (kind < 40) begin
        ex = 8'($urandom_range(100, 157));
      end else if (kind < 55) begin
        ex = 8'($urandom_range(120, 150));
        frac = frac & ~((23'd1 << $urandom_range(0, 22)) - 23'd1);
      end else if (kind < 65) begin
        ex = 8'($urandom_range(0, 3));
      end else if (kind < 72) begin
        ex = 8'($urandom_range(155, 159));
      end else if (kind < 78) begin
        ex = EXP_SPECIAL;
      end else begin
        ex = 8'($urandom());
      end
      bits = {1'($urandom()), ex, frac};
      if ($urandom_range(0, 9) == 0) places = 4'($urandom_range(10, 15));
      else places = 4'($urandom_range(0, PLACES_CAP));
      send_value(bits, places);
    end
  endtask

  initial begin
    int unsigned waited;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    idle_on = 1'b0;
    mismatch_count = 0;
    values_sent = 0;
    results_seen = 0;
    overflows_seen = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_rounding();
    idle_on = 1'b1;
    test_special_encodings();
    test_place_clamp();
    test_random_values(2000);
    in_tvalid <= 1'b0;
    idle_on = 1'b1;

    waited = 0;
    while (pending_splits.size() > 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending_splits.size() > 0) begin
      mismatch_count += pending_splits.size();
      $display("%0d expected results never arrived", pending_splits.size());
    end

    $display("Sent %0d values over all exponent ranges, specials and clamped places.",
             values_sent);
    $display("Checked %0d results, %0d of them overflowed; %0d mismatches.",
             results_seen, overflows_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
